/* hdl/fpa_pkg.sv */
package fpa_pkg;

  localparam int unsigned FracBitsDef  = 8;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned CmdWidth     = 4;
  localparam int unsigned PortWidth    = 32;

  typedef enum logic [CmdWidth-1:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_LT  = 4'd4,
    CMD_LE  = 4'd5,
    CMD_GT  = 4'd6,
    CMD_GE  = 4'd7,
    CMD_EQ  = 4'd8,
    CMD_NE  = 4'd9,
    CMD_MIN = 4'd10,
    CMD_MAX = 4'd11,
    CMD_INC = 4'd12,
    CMD_DEC = 4'd13
  } cmd_e;

  // Result class chosen by the front end.
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_SIMPLE,
    CLS_FLAG,
    CLS_MUL,
    CLS_DIV
  } cls_e;

endpackage

/* hdl/fpa_front.sv */
module fpa_front #(
  parameter int unsigned DataWidth = fpa_pkg::DataWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [fpa_pkg::CmdWidth-1:0]        command_i,
  input  logic signed [fpa_pkg::PortWidth-1:0] operand_a_i,
  input  logic signed [fpa_pkg::PortWidth-1:0] operand_b_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output fpa_pkg::cls_e                       cls_o,
  output logic signed [DataWidth-1:0]         simple_o,
  output logic                                flag_o,
  output logic signed [DataWidth-1:0]         a_o,
  output logic signed [DataWidth-1:0]         b_o
);
  import fpa_pkg::*;

  logic signed [DataWidth-1:0] a, b;
  logic                        lt, eq;
  logic signed [DataWidth-1:0] simple_d, simple_q, a_q, b_q;
  logic                        flag_d, flag_q, valid_q;
  cls_e                        cls_d, cls_q;

  assign a  = operand_a_i[DataWidth-1:0];
  assign b  = operand_b_i[DataWidth-1:0];
  assign lt = a < b;
  assign eq = a == b;

  always_comb begin
    simple_d = '0;
    flag_d   = 1'b0;
    cls_d    = CLS_SIMPLE;
    unique case (command_i)
      CMD_ADD: simple_d = a + b;
      CMD_SUB: simple_d = a - b;
      CMD_MUL: cls_d = CLS_MUL;
      CMD_DIV: cls_d = CLS_DIV;
      CMD_LT:  begin cls_d = CLS_FLAG; flag_d = lt; end
      CMD_LE:  begin cls_d = CLS_FLAG; flag_d = lt | eq; end
      CMD_GT:  begin cls_d = CLS_FLAG; flag_d = !(lt | eq); end
      CMD_GE:  begin cls_d = CLS_FLAG; flag_d = !lt; end
      CMD_EQ:  begin cls_d = CLS_FLAG; flag_d = eq; end
      CMD_NE:  begin cls_d = CLS_FLAG; flag_d = !eq; end
      CMD_MIN: simple_d = lt ? a : b;
      CMD_MAX: simple_d = (!(lt | eq)) ? a : b;
      CMD_INC: simple_d = a + DataWidth'(1);
      CMD_DEC: simple_d = a - DataWidth'(1);
      default: cls_d = CLS_NONE;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      cls_q    <= cls_d;
      simple_q <= simple_d;
      flag_q   <= flag_d;
      a_q      <= a;
      b_q      <= b;
    end
  end

  assign valid_o  = valid_q;
  assign cls_o    = cls_q;
  assign simple_o = simple_q;
  assign flag_o   = flag_q;
  assign a_o      = a_q;
  assign b_o      = b_q;

endmodule

/* hdl/fpa_queue.sv */
module fpa_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0]  mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;
  logic              push, pop;

  assign ready_o = cnt_q != (PtrW+1)'(Depth);
  assign valid_o = cnt_q != '0;
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* hdl/fpa_back.sv */
module fpa_back #(
  parameter int unsigned DataWidth = fpa_pkg::DataWidthDef,
  parameter int unsigned FracBits  = fpa_pkg::FracBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  fpa_pkg::cls_e                        cls_i,
  input  logic signed [DataWidth-1:0]          simple_i,
  input  logic                                 flag_i,
  input  logic signed [DataWidth-1:0]          a_i,
  input  logic signed [DataWidth-1:0]          b_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [fpa_pkg::PortWidth-1:0] result_o,
  output logic                                 flag_o,
  output logic                                 div_zero_o
);
  import fpa_pkg::*;

  localparam int unsigned NumW  = DataWidth + FracBits;   // dividend width
  localparam int unsigned Steps = NumW;                   // one quotient bit per stage
  localparam int unsigned Lat   = Steps + 2;              // stage 0 setup, Steps, output
  localparam int unsigned ProdW = 2 * DataWidth;

  // Stage registers; the pipeline advances only when the last stage is empty or moves on.
  logic                  adv;
  logic [Lat-1:0]        v_q;
  cls_e                  cls_q  [Lat];
  logic [DataWidth-1:0]  sim_q  [Lat];
  logic                  flg_q  [Lat];
  logic                  neg_q  [Lat];
  logic                  dz_q   [Lat];
  logic [NumW-1:0]       num_q  [Lat];
  logic [DataWidth-1:0]  den_q  [Lat];
  logic [DataWidth:0]    rem_q  [Lat];
  logic [ProdW-1:0]      prod_q;
  logic [DataWidth-1:0]  mag_a, mag_b;

  assign adv     = !v_q[Lat-1] || ready_i;
  assign ready_o = adv;
  assign mag_a   = a_i[DataWidth-1] ? DataWidth'(-a_i) : a_i;
  assign mag_b   = b_i[DataWidth-1] ? DataWidth'(-b_i) : b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[Lat-2:0], valid_i};
    end
  end

  // Stage 0: capture magnitudes and start the product.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls_q[0] <= cls_i;
      sim_q[0] <= simple_i;
      flg_q[0] <= flag_i;
      neg_q[0] <= a_i[DataWidth-1] ^ b_i[DataWidth-1];
      dz_q[0]  <= b_i == '0;
      num_q[0] <= {mag_a, FracBits'(0)};
      den_q[0] <= mag_b;
      rem_q[0] <= '0;
      prod_q   <= ProdW'($signed(a_i) * $signed(b_i));
    end
  end

  // Restoring division: one quotient bit per stage, quotient shifts into num.
  for (genvar s = 1; s <= Steps; s++) begin : g_div
    logic [DataWidth:0] trial;
    logic [DataWidth:0] diff;
    assign trial = {rem_q[s-1][DataWidth-1:0], num_q[s-1][NumW-1]};
    assign diff  = trial - {1'b0, den_q[s-1]};
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cls_q[s] <= cls_q[s-1];
        flg_q[s] <= flg_q[s-1];
        neg_q[s] <= neg_q[s-1];
        dz_q[s]  <= dz_q[s-1];
        den_q[s] <= den_q[s-1];
        if (s == 1 && cls_q[0] == CLS_MUL) begin
          sim_q[s] <= prod_q[FracBits +: DataWidth];
        end else begin
          sim_q[s] <= sim_q[s-1];
        end
        rem_q[s] <= diff[DataWidth] ? trial : diff;
        num_q[s] <= {num_q[s-1][NumW-2:0], !diff[DataWidth]};
      end
    end
  end

  // Output stage.
  logic [DataWidth-1:0] quo;
  assign quo = num_q[Steps][DataWidth-1:0];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls_q[Lat-1] <= cls_q[Steps];
      flg_q[Lat-1] <= cls_q[Steps] == CLS_FLAG && flg_q[Steps];
      dz_q[Lat-1]  <= cls_q[Steps] == CLS_DIV && dz_q[Steps];
      neg_q[Lat-1] <= neg_q[Steps];
      num_q[Lat-1] <= num_q[Steps];
      den_q[Lat-1] <= den_q[Steps];
      rem_q[Lat-1] <= rem_q[Steps];
      case (cls_q[Steps]) inside
        CLS_SIMPLE, CLS_MUL: sim_q[Lat-1] <= sim_q[Steps];
        CLS_DIV: sim_q[Lat-1] <= dz_q[Steps] ? '0 :
                                 (neg_q[Steps] ? DataWidth'(-quo) : quo);
        default: sim_q[Lat-1] <= '0;
      endcase
    end
  end

  assign valid_o    = v_q[Lat-1];
  assign result_o   = PortWidth'($signed(sim_q[Lat-1]));
  assign flag_o     = flg_q[Lat-1];
  assign div_zero_o = dz_q[Lat-1];

endmodule

/* hdl/fixed_point_alu.sv */
// Signed fixed-point ALU, raw two's complement operands with FRAC_BITS fraction bits.
// Input channel: valid_i/ready_o with command_i, operand_a_i, operand_b_i.
// Output channel: valid_o/ready_i with result_o, flag_o, div_zero_o; one result
// transaction per input transaction, in order.
// Front end registers the transaction and resolves add/sub/inc/dec/min/max and the
// comparisons. A two-entry queue decouples it from the back end, which holds the
// multiplier and a fully pipelined restoring divider (one quotient bit per stage).
// Every command runs through the same back-end pipeline, so order is kept.
// Throughput: one transaction per cycle when the receiver keeps ready_i high.
// On its way to valid_o a transaction passes the front-end register, a queue entry
// and the back-end stages (setup, one per quotient bit, output); the divider depth
// sets the latency.
// Reset clears all valid flags; no transaction is in flight afterwards.
// When the receiver stalls, the back-end pipeline freezes, the queue fills, and
// then ready_o drops; nothing is lost or repeated.
// Divide by zero returns 0 with div_zero_o set. Unused command codes return zeros.
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS  = fpa_pkg::FracBitsDef,
  parameter int unsigned DATA_WIDTH = fpa_pkg::DataWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic [fpa_pkg::CmdWidth-1:0]         command_i,
  input  logic signed [fpa_pkg::PortWidth-1:0] operand_a_i,
  input  logic signed [fpa_pkg::PortWidth-1:0] operand_b_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [fpa_pkg::PortWidth-1:0] result_o,
  output logic                                 flag_o,
  output logic                                 div_zero_o
);
  import fpa_pkg::*;

  localparam int unsigned QW = 3 + 1 + 3 * DATA_WIDTH;

  logic                        f_valid, f_ready, b_valid, b_ready;
  cls_e                        f_cls, b_cls;
  logic signed [DATA_WIDTH-1:0] f_sim, f_a, f_b;
  logic                        f_flag;
  logic [QW-1:0]               q_in, q_out;

  fpa_front #(.DataWidth(DATA_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .valid_i, .ready_o, .command_i, .operand_a_i, .operand_b_i,
    .valid_o(f_valid), .ready_i(f_ready),
    .cls_o(f_cls), .simple_o(f_sim), .flag_o(f_flag), .a_o(f_a), .b_o(f_b)
  );

  // Pack the classified transaction for the queue.
  assign q_in = {f_cls, f_flag, f_sim, f_a, f_b};

  fpa_queue #(.Width(QW), .Depth(2)) u_queue (
    .clk_i, .rst_ni,
    .valid_i(f_valid), .ready_o(f_ready), .data_i(q_in),
    .valid_o(b_valid), .ready_i(b_ready), .data_o(q_out)
  );

  assign b_cls = cls_e'(q_out[QW-1 -: 3]);

  fpa_back #(.DataWidth(DATA_WIDTH), .FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i(b_valid), .ready_o(b_ready),
    .cls_i(b_cls),
    .flag_i(q_out[3*DATA_WIDTH]),
    .simple_i(q_out[2*DATA_WIDTH +: DATA_WIDTH]),
    .a_i(q_out[DATA_WIDTH +: DATA_WIDTH]),
    .b_i(q_out[0 +: DATA_WIDTH]),
    .valid_o, .ready_i, .result_o, .flag_o, .div_zero_o
  );

endmodule
